[hw/rtl/quaternion_gyro_integrator_unit_defines.svh]
// ----------------------------------------------------------------------------
// quaternion_gyro_integrator_unit_defines
// Assertion macros for the quaternion gyro integrator.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_GYRO_INTEGRATOR_UNIT_DEFINES_SVH
`define QUATERNION_GYRO_INTEGRATOR_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define QGI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define QGI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/qgi_pkg.sv]
// ----------------------------------------------------------------------------
// qgi_pkg
// Shared types and constants of the quaternion gyro integrator.
// ----------------------------------------------------------------------------
package qgi_pkg;

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned Depth     = 8 + SqrtSteps + DivSteps;
  localparam logic [31:0] StepReset = 32'd4294967;

  typedef struct packed {
    logic        degen;
    logic [3:0]  sign;
    logic [30:0] m0;
    logic [30:0] m1;
    logic [30:0] m2;
    logic [30:0] m3;
  } norm_t;

  // item travelling along the root cell chain
  typedef struct packed {
    logic        degen;
    logic [3:0]  sign;
    logic [30:0] m0;
    logic [30:0] m1;
    logic [30:0] m2;
    logic [30:0] m3;
    logic [63:0] rem;
    logic [31:0] root;
  } sq_t;

  // item travelling along the divider cell chain
  typedef struct packed {
    logic        degen;
    logic [3:0]  sign;
    logic [31:0] len;
    logic [63:0] r0;
    logic [63:0] r1;
    logic [63:0] r2;
    logic [63:0] r3;
    logic [31:0] q0;
    logic [31:0] q1;
    logic [31:0] q2;
    logic [31:0] q3;
  } dv_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // signed round to nearest, ties away, by 2^s
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input int unsigned s);
    logic [63:0] m;
    logic [63:0] q;
    m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    q = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

endpackage

[hw/rtl/qgi_front.sv]
// ----------------------------------------------------------------------------
// qgi_front
// Half angles, Hamilton product and magnitude scaling, seven registered stages.
// ----------------------------------------------------------------------------
module qgi_front (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          step_time,
  input  logic signed [31:0]   pw,
  input  logic signed [31:0]   px,
  input  logic signed [31:0]   py,
  input  logic signed [31:0]   pz,
  input  logic signed [31:0]   rx,
  input  logic signed [31:0]   ry,
  input  logic signed [31:0]   rz,
  output qgi_pkg::sq_t         sq
);

  logic signed [31:0] a0w, a0x, a0y, a0z;
  logic signed [63:0] rpx, rpy, rpz;
  logic signed [31:0] a1w, a1x, a1y, a1z, hx, hy, hz;
  logic signed [63:0] t [12];
  logic signed [31:0] a2w, a2x, a2y, a2z;
  logic signed [35:0] c [4];
  logic [34:0] mx;
  logic [34:0] mgr [4];
  logic [3:0] sgr;
  qgi_pkg::norm_t nm;
  logic [34:0] mxa, mxb;
  logic [5:0] lz;
  logic [30:0] sh [4];

  always_comb begin
    mxa = (mgr[0] > mgr[1]) ? mgr[0] : mgr[1];
    mxb = (mgr[2] > mgr[3]) ? mgr[2] : mgr[3];
    mx = (mxa > mxb) ? mxa : mxb;
    lz = 6'd0;
    for (int i = 34; i >= 0; i--) begin
      if (mx[i] && lz == 6'd0) begin
        lz = 6'(i + 1);
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (lz > 6'd31) begin
        sh[k] = 31'(mgr[k] >> (lz - 6'd31));
      end else begin
        sh[k] = 31'(mgr[k] << (6'd31 - lz));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0w <= pw; a0x <= px; a0y <= py; a0z <= pz;
      rpx <= 64'(rx) * $signed({1'b0, step_time});
      rpy <= 64'(ry) * $signed({1'b0, step_time});
      rpz <= 64'(rz) * $signed({1'b0, step_time});
      a1w <= a0w; a1x <= a0x; a1y <= a0y; a1z <= a0z;
      hx <= qgi_pkg::sat32(qgi_pkg::rnd(rpx, 19));
      hy <= qgi_pkg::sat32(qgi_pkg::rnd(rpy, 19));
      hz <= qgi_pkg::sat32(qgi_pkg::rnd(rpz, 19));
      a2w <= a1w; a2x <= a1x; a2y <= a1y; a2z <= a1z;
      t[0] <= 64'(a1x) * 64'(hx); t[1] <= 64'(a1y) * 64'(hy);
      t[2] <= 64'(a1z) * 64'(hz); t[3] <= 64'(a1w) * 64'(hx);
      t[4] <= 64'(a1y) * 64'(hz); t[5] <= 64'(a1z) * 64'(hy);
      t[6] <= 64'(a1w) * 64'(hy); t[7] <= 64'(a1z) * 64'(hx);
      t[8] <= 64'(a1x) * 64'(hz); t[9] <= 64'(a1w) * 64'(hz);
      t[10] <= 64'(a1x) * 64'(hy); t[11] <= 64'(a1y) * 64'(hx);
      c[0] <= 36'(a2w) - 36'(qgi_pkg::rnd(t[0], 30)) - 36'(qgi_pkg::rnd(t[1], 30))
              - 36'(qgi_pkg::rnd(t[2], 30));
      c[1] <= 36'(a2x) + 36'(qgi_pkg::rnd(t[3], 30)) + 36'(qgi_pkg::rnd(t[4], 30))
              - 36'(qgi_pkg::rnd(t[5], 30));
      c[2] <= 36'(a2y) + 36'(qgi_pkg::rnd(t[6], 30)) + 36'(qgi_pkg::rnd(t[7], 30))
              - 36'(qgi_pkg::rnd(t[8], 30));
      c[3] <= 36'(a2z) + 36'(qgi_pkg::rnd(t[9], 30)) + 36'(qgi_pkg::rnd(t[10], 30))
              - 36'(qgi_pkg::rnd(t[11], 30));
      for (int k = 0; k < 4; k++) begin
        mgr[k] <= c[k][35] ? 35'(-c[k]) : 35'(c[k]);
        sgr[k] <= c[k][35];
      end
      nm.degen <= (mx == 35'd0);
      nm.sign  <= sgr;
      nm.m0 <= sh[0]; nm.m1 <= sh[1]; nm.m2 <= sh[2]; nm.m3 <= sh[3];
      sq.degen <= nm.degen;
      sq.sign  <= nm.sign;
      sq.m0 <= nm.m0; sq.m1 <= nm.m1; sq.m2 <= nm.m2; sq.m3 <= nm.m3;
      sq.rem <= 64'(nm.m0) * 64'(nm.m0) + 64'(nm.m1) * 64'(nm.m1)
              + 64'(nm.m2) * 64'(nm.m2) + 64'(nm.m3) * 64'(nm.m3);
      sq.root <= 32'd0;
    end
  end

endmodule

[hw/rtl/qgi_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// qgi_sqrt_cell
// One digit of the restoring integer square root.
// ----------------------------------------------------------------------------
module qgi_sqrt_cell (
  input  logic          clk,
  input  logic          en,
  input  logic [4:0]    idx,
  input  qgi_pkg::sq_t  din,
  output qgi_pkg::sq_t  dout
);

  logic [63:0] trial;
  logic [63:0] bitv;
  qgi_pkg::sq_t dout_next;

  always_comb begin
    bitv  = 64'd1 << {idx, 1'b0};
    trial = ({32'd0, din.root} << idx) + ({32'd0, din.root} << idx) + bitv;
    dout_next = din;
    if (din.rem >= trial) begin
      dout_next.rem  = din.rem - trial;
      dout_next.root = din.root | (32'd1 << idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

[hw/rtl/qgi_div_cell.sv]
// ----------------------------------------------------------------------------
// qgi_div_cell
// One quotient bit of four restoring dividers sharing a divisor.
// ----------------------------------------------------------------------------
module qgi_div_cell (
  input  logic          clk,
  input  logic          en,
  input  qgi_pkg::dv_t  din,
  output qgi_pkg::dv_t  dout
);

  logic [64:0] s [4];
  logic [63:0] rin [4];
  logic [63:0] rout [4];
  logic [3:0]  qb;
  qgi_pkg::dv_t dout_next;

  // remainder in the upper half, dividend bits move up from the lower half
  always_comb begin
    rin[0] = din.r0; rin[1] = din.r1; rin[2] = din.r2; rin[3] = din.r3;
    for (int k = 0; k < 4; k++) begin
      s[k] = {rin[k], 1'b0} - {1'b0, din.len, 32'd0};
      qb[k] = !s[k][64] || rin[k][63];
      rout[k] = qb[k] ? s[k][63:0] : {rin[k][62:0], 1'b0};
    end
    dout_next = din;
    dout_next.r0 = rout[0]; dout_next.r1 = rout[1];
    dout_next.r2 = rout[2]; dout_next.r3 = rout[3];
    dout_next.q0 = {din.q0[30:0], qb[0]};
    dout_next.q1 = {din.q1[30:0], qb[1]};
    dout_next.q2 = {din.q2[30:0], qb[2]};
    dout_next.q3 = {din.q3[30:0], qb[3]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

[hw/rtl/quaternion_gyro_integrator_unit.sv]
// ----------------------------------------------------------------------------
// quaternion_gyro_integrator_unit
// First-order gyro integration of an orientation quaternion, unit-length out.
// ----------------------------------------------------------------------------
// Input item on s_axis: pose w,x,y,z (Q1.30) and rates x,y,z; result on m_axis:
// normalized pose and the degenerate flag in tuser. cfg writes step_time
// (reset about 1 ms); the user is to write it only while the block is idle, the block does not enforce it.
// One item is taken every cycle unless the output stalls. Items pass seven
// front stages, a chain of 32 square-root cells (one root bit each), a staging
// register and 32 divider cells (one quotient bit each), then the output register.
// The whole chain advances only when the output register is empty or is being
// taken, so a stalled receiver stops the pipe and drops s_axis_tready; every
// item in flight is kept. A valid bit per stage travels with the data.
// Reset clears the valid bits and loads the default step_time.
`include "quaternion_gyro_integrator_unit_defines.svh"

module quaternion_gyro_integrator_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // pose_w, pose_x, pose_y, pose_z, rate_x, rate_y, rate_z
  input  logic [223:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // new_w, new_x, new_y, new_z
  output logic [127:0]  m_axis_tdata,
  // degenerate
  output logic          m_axis_tuser
);

  localparam int unsigned Depth = qgi_pkg::Depth;

  logic [31:0] step_time;
  logic en;
  logic [Depth-1:0] vld;
  qgi_pkg::sq_t sqc [qgi_pkg::SqrtSteps+1];
  qgi_pkg::dv_t dvc [qgi_pkg::DivSteps+1];
  logic [31:0] rq [4];
  logic [31:0] qv [4];
  logic [3:0] osg;
  logic odg;

  assign cfg_ready = 1'b1;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= qgi_pkg::StepReset;
    end else if (cfg_valid) begin
      step_time <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], s_axis_tvalid};
      m_axis_tvalid <= vld[Depth-1];
    end
  end

  qgi_front u_front (
    .clk(clk), .en(en), .step_time(step_time),
    .pw(s_axis_tdata[31:0]), .px(s_axis_tdata[63:32]),
    .py(s_axis_tdata[95:64]), .pz(s_axis_tdata[127:96]),
    .rx(s_axis_tdata[159:128]), .ry(s_axis_tdata[191:160]),
    .rz(s_axis_tdata[223:192]), .sq(sqc[0])
  );

  for (genvar g = 0; g < qgi_pkg::SqrtSteps; g++) begin : g_sqrt
    qgi_sqrt_cell u_cell (
      .clk(clk), .en(en), .idx(5'(qgi_pkg::SqrtSteps - 1 - g)),
      .din(sqc[g]), .dout(sqc[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvc[0].degen <= sqc[qgi_pkg::SqrtSteps].degen;
      dvc[0].sign  <= sqc[qgi_pkg::SqrtSteps].sign;
      dvc[0].len   <= sqc[qgi_pkg::SqrtSteps].degen ? 32'd1
                      : sqc[qgi_pkg::SqrtSteps].root;
      dvc[0].r0 <= 64'(sqc[qgi_pkg::SqrtSteps].m0) << 30;
      dvc[0].r1 <= 64'(sqc[qgi_pkg::SqrtSteps].m1) << 30;
      dvc[0].r2 <= 64'(sqc[qgi_pkg::SqrtSteps].m2) << 30;
      dvc[0].r3 <= 64'(sqc[qgi_pkg::SqrtSteps].m3) << 30;
      dvc[0].q0 <= '0; dvc[0].q1 <= '0; dvc[0].q2 <= '0; dvc[0].q3 <= '0;
    end
  end

  // upper half of the dividend is below the divisor, so 32 cells give the quotient
  for (genvar g = 0; g < qgi_pkg::DivSteps; g++) begin : g_div
    qgi_div_cell u_cell (.clk(clk), .en(en), .din(dvc[g]), .dout(dvc[g+1]));
  end

  // round up when twice the remainder reaches the divisor, then apply the sign; degenerate items give zero
  always_comb begin
    osg = dvc[qgi_pkg::DivSteps].sign;
    odg = dvc[qgi_pkg::DivSteps].degen;
    rq[0] = dvc[qgi_pkg::DivSteps].r0[63:32];
    rq[1] = dvc[qgi_pkg::DivSteps].r1[63:32];
    rq[2] = dvc[qgi_pkg::DivSteps].r2[63:32];
    rq[3] = dvc[qgi_pkg::DivSteps].r3[63:32];
    qv[0] = dvc[qgi_pkg::DivSteps].q0; qv[1] = dvc[qgi_pkg::DivSteps].q1;
    qv[2] = dvc[qgi_pkg::DivSteps].q2; qv[3] = dvc[qgi_pkg::DivSteps].q3;
    for (int k = 0; k < 4; k++) begin
      if ({rq[k], 1'b0} >= {1'b0, dvc[qgi_pkg::DivSteps].len}) begin
        qv[k] = qv[k] + 32'd1;
      end
      if (odg) begin
        qv[k] = 32'd0;
      end else if (osg[k]) begin
        qv[k] = 32'd0 - qv[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {qv[3], qv[2], qv[1], qv[0]};
      m_axis_tuser <= odg;
    end
  end

  `QGI_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "item dropped while stalled")
  `QGI_ASSERT_IMP(a_ready_en, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready mismatch")
  `QGI_ASSERT_IMP(a_degen_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 128'd0, "degenerate item not zero")

endmodule

[bench/quaternion_gyro_integrator_unit_tb.sv]
// ----------------------------------------------------------------------------
// quaternion_gyro_integrator_unit_tb
// Streams pose and rate items through the integrator under random flow control
// and checks each normalized pose against an in-bench bit-exact prediction.
// ----------------------------------------------------------------------------
module quaternion_gyro_integrator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] w;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        degen;
  } pose_res_t;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [31:0]  cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;

  logic [31:0]  step_time;
  pose_res_t    pose_q[$];
  int           n_fail;
  int           n_items;
  int           n_results;
  int           n_degen;
  int           idle_cycles;
  bit           hold_off;
  bit           bursty;

  quaternion_gyro_integrator_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned mag(input longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint round_shift(input longint v, input int s);
    longint unsigned m;
    m = (mag(v) + (64'd1 << (s - 1))) >> s;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint half_term(input logic [31:0] rate);
    longint h;
    h = round_shift(longint'($signed(rate)) * longint'({32'd0, step_time}), 19);
    if (h > 64'sd2147483647) h = 64'sd2147483647;
    if (h < -64'sd2147483648) h = -64'sd2147483648;
    return h;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic pose_res_t integrate_pose(input logic [223:0] d);
    longint a[4];
    longint hx, hy, hz;
    longint c[4];
    longint unsigned m[4];
    longint unsigned mx, n, len, q;
    pose_res_t r;
    for (int i = 0; i < 4; i++) a[i] = longint'($signed(d[32*i +: 32]));
    hx = half_term(d[128 +: 32]);
    hy = half_term(d[160 +: 32]);
    hz = half_term(d[192 +: 32]);
    c[0] = a[0] - round_shift(a[1] * hx, 30) - round_shift(a[2] * hy, 30)
         - round_shift(a[3] * hz, 30);
    c[1] = a[1] + round_shift(a[0] * hx, 30) + round_shift(a[2] * hz, 30)
         - round_shift(a[3] * hy, 30);
    c[2] = a[2] + round_shift(a[0] * hy, 30) + round_shift(a[3] * hx, 30)
         - round_shift(a[1] * hz, 30);
    c[3] = a[3] + round_shift(a[0] * hz, 30) + round_shift(a[1] * hy, 30)
         - round_shift(a[2] * hx, 30);
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      m[i] = mag(c[i]);
      if (m[i] > mx) mx = m[i];
    end
    r = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
    if (mx == 0) return r;
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 4; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 4; i++) m[i] <<= 1;
    end
    n = 0;
    for (int i = 0; i < 4; i++) n += m[i] * m[i];
    len = int_sqrt(n);
    for (int i = 0; i < 4; i++) begin
      q = ((m[i] << 30) + (len >> 1)) / len;
      m[i] = c[i] < 0 ? -q : q;
    end
    r = '{m[0][31:0], m[1][31:0], m[2][31:0], m[3][31:0], 1'b0};
    return r;
  endfunction

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_item(input logic [223:0] d);
    if (bursty && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_axis_tdata <= d;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pose_q.push_back(integrate_pose(d));
    n_items++;
    @(negedge clk);
  endtask

  task automatic write_step(input logic [31:0] v);
    idle_input();
    while (pose_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    step_time = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_pose_comp();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * (1 << 30))) - (1 << 30));
      2: return 32'($signed($urandom_range(0, 4000)) - 2000);
      default: return $urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  function automatic logic [223:0] rand_item();
    logic [223:0] d;
    for (int i = 0; i < 4; i++) d[32*i +: 32] = rand_pose_comp();
    for (int i = 4; i < 7; i++) d[32*i +: 32] = rand_rate();
    return d;
  endfunction

  task automatic test_directed();
    logic [31:0] ext[6];
    ext = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h4000_0000,
            32'hc000_0000};
    send_item('0);
    send_item({96'd0, 32'd0, 32'd0, 32'd0, 32'h4000_0000});
    send_item({{3{32'h7fff_ffff}}, {4{32'h7fff_ffff}}});
    send_item({{3{32'h8000_0000}}, {4{32'h8000_0000}}});
    send_item({{3{32'h8000_0000}}, {4{32'h7fff_ffff}}});
    send_item({{3{32'hffff_ffff}}, {4{32'hffff_ffff}}});
    send_item({96'd0, 32'h0, 32'h0, 32'h0, 32'h1});
    for (int i = 0; i < 12; i++) begin
      send_item({ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
                 ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
                 ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
                 ext[$urandom_range(0, 5)]});
    end
  endtask

  task automatic test_step_settings();
    logic [31:0] steps[4];
    steps = '{32'd0, 32'hffff_ffff, 32'd1, $urandom()};
    foreach (steps[k]) begin
      write_step(steps[k]);
      send_item({96'd0, 32'h4000_0000, 32'h0, 32'h0, 32'h0} | {96'h1_0000_0001_0000, 128'd0});
      send_item({{3{32'h7fff_ffff}}, 32'h0, 32'h0, 32'h0, 32'h4000_0000});
      for (int i = 0; i < 40; i++) send_item(rand_item());
    end
    write_step(qgi_pkg::StepReset);
  endtask

  task automatic test_random();
    bursty = 1'b1;
    for (int i = 0; i < 300; i++) send_item(rand_item());
    write_step($urandom_range(0, 1 << 24));
    for (int i = 0; i < 300; i++) send_item(rand_item());
  endtask

  task automatic test_backpressure();
    bursty = 1'b0;
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 150; i++) send_item(rand_item());
    join
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else begin
        case ((n_results / 64) % 3)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    pose_res_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (pose_q.size() == 0) begin
        $error("result with nothing expected");
        n_fail++;
      end else begin
        e = pose_q.pop_front();
        if (e.degen) n_degen++;
        if (m_axis_tdata[31:0] !== e.w) begin
          $error("new_w exp %h got %h", e.w, m_axis_tdata[31:0]);
          n_fail++;
        end
        if (m_axis_tdata[63:32] !== e.x) begin
          $error("new_x exp %h got %h", e.x, m_axis_tdata[63:32]);
          n_fail++;
        end
        if (m_axis_tdata[95:64] !== e.y) begin
          $error("new_y exp %h got %h", e.y, m_axis_tdata[95:64]);
          n_fail++;
        end
        if (m_axis_tdata[127:96] !== e.z) begin
          $error("new_z exp %h got %h", e.z, m_axis_tdata[127:96]);
          n_fail++;
        end
        if (m_axis_tuser !== e.degen) begin
          $error("degenerate exp %b got %b", e.degen, m_axis_tuser);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready) || hold_off) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 2000) begin
      $display("quaternion_gyro_integrator_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    n_fail = 0;
    n_items = 0;
    n_results = 0;
    n_degen = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    bursty = 1'b0;
    step_time = qgi_pkg::StepReset;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_step_settings();
    test_backpressure();
    test_random();
    idle_input();
    while (pose_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Sent %0d items, checked %0d results (%0d degenerate),", n_items, n_results,
             n_degen);
    $display("over several step_time settings with input gaps and output stalls.");
    if (n_fail == 0 && pose_q.size() == 0) begin
      $display("quaternion_gyro_integrator_unit_tb: PASS");
    end else begin
      $display("quaternion_gyro_integrator_unit_tb: FAIL");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/qgi_pkg.sv
hw/rtl/qgi_front.sv
hw/rtl/qgi_sqrt_cell.sv
hw/rtl/qgi_div_cell.sv
hw/rtl/quaternion_gyro_integrator_unit.sv
bench/quaternion_gyro_integrator_unit_tb.sv
